// File: hw/rtl/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam int SLOT_BITS   = 4;
   localparam int COUNT_BITS  = 5;
   localparam int APB_DATA    = 32;
   localparam int APB_ADDR    = 3;

   // register index taken from the word address
   localparam logic REG_ACTIVE_PARTITIONS = 1'b0;

   // control half of the item travelling down the chain
   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic       hit;
   } token_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/ffpa_cell.sv
`default_nettype none
module ffpa_cell #(
   parameter int IDX          = 0,
   parameter int SIZE_BITS    = 16,
   parameter int JOB_ID_BITS  = 8,
   parameter int IDX_BITS     = 4
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [ffpa_pkg::COUNT_BITS-1:0]     cfg_count,
   input  wire  ffpa_pkg::token_ctl_type       ctl_in,
   input  wire  [ffpa_pkg::SLOT_BITS-1:0]      slot_in,
   input  wire  [SIZE_BITS-1:0]                size_in,
   input  wire  [JOB_ID_BITS-1:0]              job_in,
   input  wire  [IDX_BITS-1:0]                 found_in,
   output ffpa_pkg::token_ctl_type             ctl_out,
   output logic [ffpa_pkg::SLOT_BITS-1:0]      slot_out,
   output logic [SIZE_BITS-1:0]                size_out,
   output logic [JOB_ID_BITS-1:0]              job_out,
   output logic [IDX_BITS-1:0]                 found_out
);

   logic [SIZE_BITS-1:0]    part_size_ff, part_size_in;
   logic                    owned_ff, owned_in;
   logic [JOB_ID_BITS-1:0]  owner_ff, owner_in;

   ffpa_pkg::token_ctl_type ctl_ff, ctl_in_nxt;
   logic [ffpa_pkg::SLOT_BITS-1:0] slot_ff;
   logic [SIZE_BITS-1:0]    size_ff;
   logic [JOB_ID_BITS-1:0]  job_ff;
   logic [IDX_BITS-1:0]     found_ff, found_in_nxt;

   logic active;
   logic claim;

   // slot IDX lies below N_PARTITIONS, so comparing against the raw count clamps for free
   assign active = (32'(cfg_count) > IDX);

   always_comb begin
      part_size_in = part_size_ff;
      owned_in     = owned_ff;
      owner_in     = owner_ff;
      claim        = 1'b0;
      if (ctl_in.valid) begin
         unique case (ctl_in.op)
            ffpa_pkg::OP_LOAD: begin
               if (32'(slot_in) == IDX) begin
                  part_size_in = size_in;
                  owned_in     = 1'b0;
                  claim        = 1'b1;
               end
            end
            ffpa_pkg::OP_ALLOC: begin
               if (!ctl_in.hit && active && !owned_ff && part_size_ff >= size_in) begin
                  owned_in = 1'b1;
                  owner_in = job_in;
                  claim    = 1'b1;
               end
            end
            ffpa_pkg::OP_FREE: begin
               if (!ctl_in.hit && active && owned_ff && owner_ff == job_in) begin
                  owned_in = 1'b0;
                  claim    = 1'b1;
               end
            end
            default: ;
         endcase
      end
      ctl_in_nxt     = ctl_in;
      found_in_nxt   = found_in;
      if (claim) begin
         ctl_in_nxt.hit = 1'b1;
         found_in_nxt   = IDX_BITS'(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owned_ff     <= 1'b0;
         ctl_ff.valid <= 1'b0;
      end else begin
         owned_ff     <= owned_in;
         ctl_ff.valid <= ctl_in_nxt.valid;
      end
      part_size_ff <= part_size_in;
      owner_ff     <= owner_in;
      ctl_ff.op    <= ctl_in_nxt.op;
      ctl_ff.hit   <= ctl_in_nxt.hit;
      slot_ff      <= slot_in;
      size_ff      <= size_in;
      job_ff       <= job_in;
      found_ff     <= found_in_nxt;
   end

   assign ctl_out   = ctl_ff;
   assign slot_out  = slot_ff;
   assign size_out  = size_ff;
   assign job_out   = job_ff;
   assign found_out = found_ff;

endmodule
`default_nettype wire

// File: hw/rtl/first_fit_partition_allocator.sv
`default_nettype none
// A result strobes once the item has passed the head register and the register of every slot cell.
// A new item is taken only once the last result is shown; the item walks the row of slot cells,
// one cell per cycle, and busy drops in the cycle its result is shown.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per item.
// Reset (synchronous): every slot free, active_partitions 0, nothing in flight.
// Partition sizes and owners are not cleared by reset.
module first_fit_partition_allocator #(
   parameter int N_PARTITIONS = 16,
   parameter int JOB_ID_BITS  = 8,
   parameter int SIZE_BITS    = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [1:0]                          req_op,
   input  wire  [ffpa_pkg::SLOT_BITS-1:0]      req_slot,
   input  wire  [SIZE_BITS-1:0]                req_size_kb,
   input  wire  [JOB_ID_BITS-1:0]              req_job_id,
   output logic                                rsp_valid,
   output logic                                rsp_ok,
   output logic [ffpa_pkg::SLOT_BITS-1:0]      rsp_found_slot,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [ffpa_pkg::APB_ADDR-1:0]       paddr,
   input  wire  [ffpa_pkg::APB_DATA-1:0]       pwdata,
   output logic [ffpa_pkg::APB_DATA-1:0]       prdata,
   output logic                                pready
);

   localparam int IDX_BITS = (N_PARTITIONS > 1) ? $clog2(N_PARTITIONS) : 1;

   logic [ffpa_pkg::COUNT_BITS-1:0] active_ff;
   logic busy_ff;
   logic accept;

   ffpa_pkg::token_ctl_type           ctl_chain   [0:N_PARTITIONS];
   logic [ffpa_pkg::SLOT_BITS-1:0]    slot_chain  [0:N_PARTITIONS];
   logic [SIZE_BITS-1:0]              size_chain  [0:N_PARTITIONS];
   logic [JOB_ID_BITS-1:0]            job_chain   [0:N_PARTITIONS];
   logic [IDX_BITS-1:0]               found_chain [0:N_PARTITIONS];
   logic [N_PARTITIONS:0]             valid_vec;

   ffpa_pkg::token_ctl_type           head_ctl_ff;
   logic [ffpa_pkg::SLOT_BITS-1:0]    head_slot_ff;
   logic [SIZE_BITS-1:0]              head_size_ff;
   logic [JOB_ID_BITS-1:0]            head_job_ff;

   assign pready = 1'b1;
   assign prdata = ffpa_pkg::APB_DATA'(active_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (psel && penable && pwrite &&
                   paddr[2] == ffpa_pkg::REG_ACTIVE_PARTITIONS) begin
         active_ff <= pwdata[ffpa_pkg::COUNT_BITS-1:0];
      end
   end

   assign busy   = busy_ff && !rsp_valid;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff           <= 1'b0;
         head_ctl_ff.valid <= 1'b0;
      end else begin
         priority if (accept) begin
            busy_ff <= 1'b1;
         end else if (rsp_valid) begin
            busy_ff <= 1'b0;
         end else begin
            busy_ff <= busy_ff;
         end
         head_ctl_ff.valid <= accept;
      end
      head_ctl_ff.op  <= req_op;
      head_ctl_ff.hit <= 1'b0;
      head_slot_ff    <= req_slot;
      head_size_ff    <= req_size_kb;
      head_job_ff     <= req_job_id;
   end

   assign ctl_chain[0]   = head_ctl_ff;
   assign slot_chain[0]  = head_slot_ff;
   assign size_chain[0]  = head_size_ff;
   assign job_chain[0]   = head_job_ff;
   assign found_chain[0] = '0;

   for (genvar k = 0; k < N_PARTITIONS; k++) begin : g_cell
      ffpa_cell #(
         .IDX          (k),
         .SIZE_BITS    (SIZE_BITS),
         .JOB_ID_BITS  (JOB_ID_BITS),
         .IDX_BITS     (IDX_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg_count (active_ff),
         .ctl_in    (ctl_chain[k]),
         .slot_in   (slot_chain[k]),
         .size_in   (size_chain[k]),
         .job_in    (job_chain[k]),
         .found_in  (found_chain[k]),
         .ctl_out   (ctl_chain[k+1]),
         .slot_out  (slot_chain[k+1]),
         .size_out  (size_chain[k+1]),
         .job_out   (job_chain[k+1]),
         .found_out (found_chain[k+1])
      );
   end

   for (genvar k = 0; k <= N_PARTITIONS; k++) begin : g_valid
      assign valid_vec[k] = ctl_chain[k].valid;
   end

   assign rsp_valid      = ctl_chain[N_PARTITIONS].valid;
   assign rsp_ok         = ctl_chain[N_PARTITIONS].hit;
   assign rsp_found_slot = ffpa_pkg::SLOT_BITS'(found_chain[N_PARTITIONS]);

   // at most one item in the row of cells
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0(valid_vec))
      else $error("more than one item in the cell chain");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(N_PARTITIONS + 1) rsp_valid)
      else $error("result did not appear after the chain latency");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_found_slot == '0))
      else $error("failed item reports a nonzero slot");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff)
      else $error("result without an item in flight");

endmodule
`default_nettype wire
